// ===== rtl/core/pws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_pkg
// types, constants and table functions of the periodic waveform sample unit
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int TIME_W     = 24;
    localparam int PHASE_W    = 32;
    localparam int FREQ_W     = 32;
    localparam int PERIOD_W   = 24;
    localparam int HCOUNT_W   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 31;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W      = 60;
    localparam int DIV_W      = 27;
    localparam int SPAN_W     = 26;
    localparam int TRI_PROD_W = 59;

    localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
    localparam longint      FOUR_OVER_PI_Q30 = 64'd1367130551;
    localparam longint      TWO_OVER_PI_Q30  = 64'd683565276;
    localparam logic [63:0] ONE_Q30          = 64'd1 << 30;

    typedef enum logic [1:0] {
        KIND_SINE,
        KIND_TRIANGLE,
        KIND_SQUARE,
        KIND_SAWTOOTH
    } wave_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KIND   = 8'd0,
        REG_FREQ   = 8'd1,
        REG_PERIOD = 8'd2,
        REG_HCOUNT = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRI_DIV,
        ST_TRI_MUL,
        ST_TRI_SUB,
        ST_SUM,
        ST_ROUND
    } back_state_t;

    typedef struct packed {
        wave_kind_t            kind;
        logic [FREQ_W-1:0]     freq_step;
        logic [PERIOD_W-1:0]   period_ticks;
        logic [HCOUNT_W-1:0]   harmonic_count;
    } cfg_t;

    typedef struct packed {
        wave_kind_t           kind;
        logic [TIME_W-1:0]    phase_time;
        logic [PHASE_W-1:0]   phi;
    } job_t;

    function automatic logic [63:0] sin_quarter_q30(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] h;
        x2 = (x * x) >> 30;
        h  = ONE_Q30;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd110;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
        return (x * h) >> 30;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned k, int unsigned bits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        quarter = 64'd1 << (bits - 2);
        q = 64'(k) >> (bits - 2);
        r = 64'(k) & (quarter - 64'd1);
        if (q[0])
            r = quarter - r;
        s = sin_quarter_q30((r * HALF_PI_Q30) >> (bits - 2));
        v = (s + (64'd1 << 14)) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        if (q >= 64'd2)
            return SAMPLE_W'(64'd0 - v);
        return SAMPLE_W'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pws_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_front
// accepts requests, computes the base phase and tags the waveform kind
// ----------------------------------------------------------------------------
module pws_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pws_pkg::TIME_W-1:0]    phase_time,
    input  wire pws_pkg::cfg_t                 cfg,
    output logic                               push,
    input  wire logic                          push_ready,
    output pws_pkg::job_t                      push_job
);

    logic                         t_valid_reg;
    logic                         t_valid_next;
    logic [pws_pkg::TIME_W-1:0]   t_reg;
    logic [pws_pkg::TIME_W-1:0]   t_next;
    logic [55:0]                  phi_full;

    assign in_ready = !t_valid_reg || push_ready;
    assign push     = t_valid_reg;
    assign phi_full = 56'(t_reg) * 56'(cfg.freq_step);

    always_comb
    begin
        push_job.kind       = cfg.kind;
        push_job.phase_time = t_reg;
        push_job.phi        = phi_full[pws_pkg::PHASE_W-1:0];
    end

    always_comb
    begin
        t_valid_next = t_valid_reg;
        t_next       = t_reg;
        if (push && push_ready)
            t_valid_next = 1'b0;
        if (in_valid && in_ready)
        begin
            t_valid_next = 1'b1;
            t_next       = phase_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else
            t_valid_reg <= t_valid_next;
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/pws_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module pws_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  push_ready,
    input  wire pws_pkg::job_t    push_job,
    output logic                  pop_valid,
    input  wire logic             pop,
    output pws_pkg::job_t         pop_job
);

    pws_pkg::job_t  entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

// ===== rtl/core/pws_sine_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_sine_rom
// full-cycle sine table in q1.15 with registered read
// ----------------------------------------------------------------------------
module pws_sine_rom
#(
    parameter int TABLE_BITS = 10
)
(
    input  wire logic                            clk,
    input  wire logic [TABLE_BITS-1:0]           addr,
    output logic [pws_pkg::SAMPLE_W-1:0]         data
);

    localparam int DEPTH = 1 << TABLE_BITS;

    logic [pws_pkg::SAMPLE_W-1:0] tbl [DEPTH];
    logic [pws_pkg::SAMPLE_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_tbl
        localparam logic [pws_pkg::SAMPLE_W-1:0] VAL =
            pws_pkg::sine_entry(k, TABLE_BITS);
        assign tbl[k] = VAL;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tbl[addr];
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pws_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_back
// sample engine: harmonic sum over a shared multiplier, triangle divider,
// rounding, saturation and output register
// ----------------------------------------------------------------------------
module pws_back
#(
    parameter int MAX_HARMONICS   = 32,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pws_pkg::cfg_t                   cfg,
    input  wire logic                            job_valid,
    output logic                                 job_pop,
    input  wire pws_pkg::job_t                   job,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pws_pkg::SAMPLE_W-1:0]         sample,
    output logic                                 clipped
);

    localparam int NW = $clog2(MAX_HARMONICS + 1);
    localparam int IW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CW = pws_pkg::COEF_W;
    localparam int AW = pws_pkg::ACC_W;

    logic [CW-1:0] sq_coef  [MAX_HARMONICS];
    logic [CW-1:0] saw_coef [MAX_HARMONICS];

    for (genvar g = 0; g < MAX_HARMONICS; g++)
    begin : g_coef
        localparam longint KS = 2 * g + 1;
        localparam longint KW = g + 1;
        localparam logic [CW-1:0] CS = CW'((pws_pkg::FOUR_OVER_PI_Q30 + KS / 2) / KS);
        localparam logic [CW-1:0] CA = CW'((pws_pkg::TWO_OVER_PI_Q30 + KW / 2) / KW);
        assign sq_coef[g]  = CS;
        assign saw_coef[g] = CA;
    end

    pws_pkg::back_state_t                 state_reg, state_next;
    pws_pkg::wave_kind_t                  kind_reg, kind_next;
    logic [pws_pkg::PHASE_W-1:0]          ph_reg, ph_next;
    logic [pws_pkg::PHASE_W-1:0]          step_reg, step_next;
    logic [NW-1:0]                        n_reg, n_next;
    logic [NW-1:0]                        h_reg, h_next;
    logic                                 p1_valid_reg, p1_valid_next;
    logic                                 p1_neg_reg, p1_neg_next;
    logic [CW-1:0]                        p1_coef_reg, p1_coef_next;
    logic                                 p2_valid_reg, p2_valid_next;
    logic                                 p2_neg_reg, p2_neg_next;
    logic signed [pws_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [AW-1:0]                 acc_reg, acc_next;
    logic [pws_pkg::DIV_W-1:0]            div_x_reg, div_x_next;
    logic [pws_pkg::DIV_W-1:0]            rem_reg, rem_next;
    logic [pws_pkg::SPAN_W-1:0]           span_reg, span_next;
    logic [4:0]                           bit_cnt_reg, bit_cnt_next;
    logic [pws_pkg::TRI_PROD_W-1:0]       tri_prod_reg, tri_prod_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [pws_pkg::SAMPLE_W-1:0]         sample_reg, sample_next;
    logic                                 clipped_reg, clipped_next;

    logic [pws_pkg::SAMPLE_W-1:0]         rom_data;
    logic [pws_pkg::PERIOD_W-1:0]         per;
    logic [pws_pkg::DIV_W-1:0]            rem_sh;
    logic signed [27:0]                   tri_diff;
    logic [26:0]                          tri_d;
    logic [NW-1:0]                        h_clamp;
    logic [CW-1:0]                        coef_sel;
    logic                                 acc_neg;
    logic [AW-1:0]                        mag;
    logic [AW-1:0]                        rnd;
    logic                                 sat;
    logic [pws_pkg::SAMPLE_W-1:0]         mag16;

    pws_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (ph_reg[pws_pkg::PHASE_W-1 -: SINE_TABLE_BITS]),
        .data (rom_data)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign clipped   = clipped_reg;
    assign job_pop   = (state_reg == pws_pkg::ST_IDLE) && job_valid;

    assign per      = (cfg.period_ticks == '0) ? pws_pkg::PERIOD_W'(1) : cfg.period_ticks;
    assign rem_sh   = {rem_reg[pws_pkg::DIV_W-2:0], div_x_reg[pws_pkg::DIV_W-1]};
    assign tri_diff = $signed({1'b0, rem_reg}) - $signed({2'b00, span_reg[pws_pkg::SPAN_W-1:1]});
    assign tri_d    = tri_diff[27] ? 27'(-tri_diff) : 27'(tri_diff);
    assign h_clamp  = (int'(cfg.harmonic_count) > MAX_HARMONICS) ?
                      NW'(MAX_HARMONICS) : NW'(cfg.harmonic_count);

    always_comb
    begin
        case (kind_reg)
            pws_pkg::KIND_SQUARE:   coef_sel = sq_coef[n_reg[IW-1:0]];
            pws_pkg::KIND_SAWTOOTH: coef_sel = saw_coef[n_reg[IW-1:0]];
            default:                coef_sel = CW'(1);
        endcase
    end

    // round to q2.13, ties away from zero, then saturate
    always_comb
    begin
        acc_neg = acc_reg[AW-1];
        mag     = acc_neg ? AW'(-acc_reg) : AW'(acc_reg);
        case (kind_reg)
            pws_pkg::KIND_SINE:     rnd = (mag + (AW'(1) << 1)) >> 2;
            pws_pkg::KIND_TRIANGLE: rnd = (mag + (AW'(1) << 18)) >> 19;
            default:                rnd = (mag + (AW'(1) << 31)) >> 32;
        endcase
        if (acc_neg)
            sat = (rnd > AW'(32768));
        else
            sat = (rnd > AW'(32767));
        if (sat)
            mag16 = acc_neg ? 16'h8000 : 16'h7fff;
        else
            mag16 = rnd[pws_pkg::SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ph_next        = ph_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        h_next         = h_reg;
        p1_valid_next  = 1'b0;
        p1_neg_next    = p1_neg_reg;
        p1_coef_next   = p1_coef_reg;
        p2_valid_next  = p1_valid_reg;
        p2_neg_next    = p1_neg_reg;
        prod_next      = $signed(rom_data) * $signed({1'b0, p1_coef_reg});
        acc_next       = acc_reg;
        div_x_next     = div_x_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        bit_cnt_next   = bit_cnt_reg;
        tri_prod_next  = tri_prod_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        clipped_next   = clipped_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            pws_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    kind_next = job.kind;
                    ph_next   = job.phi;
                    step_next = (job.kind == pws_pkg::KIND_SQUARE) ?
                                {job.phi[pws_pkg::PHASE_W-2:0], 1'b0} : job.phi;
                    h_next    = (job.kind == pws_pkg::KIND_SINE) ? NW'(1) : h_clamp;
                    n_next    = '0;
                    acc_next  = '0;
                    if (job.kind == pws_pkg::KIND_TRIANGLE)
                    begin
                        div_x_next   = pws_pkg::DIV_W'({job.phase_time, 2'b00})
                                     + pws_pkg::DIV_W'(per) * pws_pkg::DIV_W'(3);
                        rem_next     = '0;
                        span_next    = {per, 2'b00};
                        bit_cnt_next = '0;
                        state_next   = pws_pkg::ST_TRI_DIV;
                    end
                    else
                        state_next = pws_pkg::ST_SUM;
                end
            end
            pws_pkg::ST_TRI_DIV:
            begin
                div_x_next = {div_x_reg[pws_pkg::DIV_W-2:0], 1'b0};
                if (rem_sh >= pws_pkg::DIV_W'(span_reg))
                    rem_next = rem_sh - pws_pkg::DIV_W'(span_reg);
                else
                    rem_next = rem_sh;
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(pws_pkg::DIV_W - 1))
                    state_next = pws_pkg::ST_TRI_MUL;
            end
            pws_pkg::ST_TRI_MUL:
            begin
                tri_prod_next = pws_pkg::TRI_PROD_W'(cfg.freq_step)
                              * pws_pkg::TRI_PROD_W'(tri_d);
                state_next    = pws_pkg::ST_TRI_SUB;
            end
            pws_pkg::ST_TRI_SUB:
            begin
                acc_next   = $signed(AW'(tri_prod_reg)) - $signed(AW'(1) << 32);
                state_next = pws_pkg::ST_ROUND;
            end
            pws_pkg::ST_SUM:
            begin
                if (n_reg != h_reg)
                begin
                    p1_valid_next = 1'b1;
                    p1_coef_next  = coef_sel;
                    p1_neg_next   = (kind_reg == pws_pkg::KIND_SAWTOOTH) && n_reg[0];
                    ph_next       = ph_reg + step_reg;
                    n_next        = n_reg + NW'(1);
                end
                if (p2_valid_reg)
                    acc_next = p2_neg_reg ? acc_reg - AW'(prod_reg) : acc_reg + AW'(prod_reg);
                if (n_reg == h_reg && !p1_valid_reg && !p2_valid_reg)
                    state_next = pws_pkg::ST_ROUND;
            end
            pws_pkg::ST_ROUND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = acc_neg ? 16'(-mag16) : mag16;
                    clipped_next   = sat;
                    state_next     = pws_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pws_pkg::ST_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        ph_reg       <= ph_next;
        step_reg     <= step_next;
        n_reg        <= n_next;
        h_reg        <= h_next;
        p1_neg_reg   <= p1_neg_next;
        p1_coef_reg  <= p1_coef_next;
        p2_neg_reg   <= p2_neg_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        div_x_reg    <= div_x_next;
        rem_reg      <= rem_next;
        span_reg     <= span_next;
        bit_cnt_reg  <= bit_cnt_next;
        tri_prod_reg <= tri_prod_next;
        sample_reg   <= sample_next;
        clipped_reg  <= clipped_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/periodic_waveform_sample_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_waveform_sample_unit
// one signed q2.13 oscillator sample per request for the configured waveform
//
// s_tdata carries an elapsed time in ticks; m_tdata returns the sample and a
// saturation flag. Waveform, frequency step, period and harmonic count are
// written through the cfg port; the user must write them only while the unit
// is idle, as the unit itself does not enforce this. An accepted request
// passes through the time register, then the phase multiply into the queue,
// before it reaches the back engine. From there sine takes a single term,
// square and sawtooth sum one harmonic term per cycle through the shared sine
// table and multiplier, and triangle runs the 27-step bit-serial modulo unit.
// The back picks up the next request only from idle, after finishing the last.
// A two-entry queue lets the front keep taking requests while the back
// works, and the output register holds a result while the receiver stalls;
// the back waits in rounding until that register frees up.
// Reset clears all handshake state and loads the register defaults
// (sine, zero frequency, full period, one harmonic).
// ----------------------------------------------------------------------------
module periodic_waveform_sample_unit
#(
    parameter int MAX_HARMONICS   = 32,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [23:0]                         s_tdata,    // phase_time
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata,    // sample, clipped
    input  wire logic                                cfg_wr_en,
    input  wire logic [pws_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [pws_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    pws_pkg::cfg_t                 cfg_reg;
    pws_pkg::cfg_t                 cfg_next;
    logic                          push;
    logic                          push_ready;
    pws_pkg::job_t                 push_job;
    logic                          pop_valid;
    logic                          pop;
    pws_pkg::job_t                 pop_job;
    logic [pws_pkg::SAMPLE_W-1:0]  sample;
    logic                          clipped;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                pws_pkg::REG_KIND:
                    cfg_next.kind = pws_pkg::wave_kind_t'(cfg_wr_data[1:0]);
                pws_pkg::REG_FREQ:
                    cfg_next.freq_step = cfg_wr_data;
                pws_pkg::REG_PERIOD:
                    cfg_next.period_ticks = cfg_wr_data[pws_pkg::PERIOD_W-1:0];
                pws_pkg::REG_HCOUNT:
                    cfg_next.harmonic_count = cfg_wr_data[pws_pkg::HCOUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind           <= pws_pkg::KIND_SINE;
            cfg_reg.freq_step      <= '0;
            cfg_reg.period_ticks   <= '1;
            cfg_reg.harmonic_count <= pws_pkg::HCOUNT_W'(1);
        end
        else
            cfg_reg <= cfg_next;
    end

    pws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .phase_time (s_tdata),
        .cfg        (cfg_reg),
        .push       (push),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    pws_back #(
        .MAX_HARMONICS   (MAX_HARMONICS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job_pop   (pop),
        .job       (pop_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sample    (sample),
        .clipped   (clipped)
    );

    assign m_tdata = {7'b0, clipped, sample};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the periodic waveform sample unit
//
// Drives elapsed times through the input stream under several register
// settings, predicts each sample and clip flag in fixed point, and checks
// every returned result in order against the predicted samples.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_BITS = 10;
    localparam int MAX_H      = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] sample;
        logic        clipped;
    } sample_t;

    class sample_board;
        logic [15:0]         sine_tab [0:(1<<TABLE_BITS)-1];
        pws_pkg::wave_kind_t kind;
        logic [31:0]         freq;
        logic [23:0]         period;
        logic [5:0]          hcount;
        sample_t             pending[$];
        int                  errors;

        function new();
            for (int k = 0; k < (1 << TABLE_BITS); k++)
                sine_tab[k] = pws_pkg::sine_entry(k, TABLE_BITS);
            kind = pws_pkg::KIND_SINE;
            freq = '0;
            period = 24'hFFFFFF;
            hcount = 6'd1;
            errors = 0;
        endfunction

        function void set_reg(pws_pkg::cfg_reg_t idx, logic [31:0] val);
            case (idx)
                pws_pkg::REG_KIND:   kind = pws_pkg::wave_kind_t'(val[1:0]);
                pws_pkg::REG_FREQ:   freq = val;
                pws_pkg::REG_PERIOD: period = val[23:0];
                pws_pkg::REG_HCOUNT: hcount = val[5:0];
                default: ;
            endcase
        endfunction

        function longint table_at(logic [31:0] ph);
            return longint'($signed(sine_tab[ph[31:32-TABLE_BITS]]));
        endfunction

        function sample_t round_sat(longint acc, int shift);
            sample_t     r;
            logic        neg;
            logic [63:0] m;
            neg = acc < 0;
            m = neg ? 64'(-acc) : 64'(acc);
            m = (m + (64'd1 << (shift - 1))) >> shift;
            r.clipped = 1'b0;
            if (!neg && m > 64'd32767)
            begin
                m = 64'd32767;
                r.clipped = 1'b1;
            end
            if (neg && m > 64'd32768)
            begin
                m = 64'd32768;
                r.clipped = 1'b1;
            end
            r.sample = neg ? 16'(64'd0 - m) : m[15:0];
            return r;
        endfunction

        function void note_time(logic [23:0] t);
            logic [31:0] phi;
            longint acc, p, span, m, d, k, coef, term;
            int h;
            phi = 32'(64'(t) * 64'(freq));
            h = (int'(hcount) > MAX_H) ? MAX_H : int'(hcount);
            acc = 0;
            case (kind)
                pws_pkg::KIND_SINE: pending.push_back(round_sat(table_at(phi), 2));
                pws_pkg::KIND_TRIANGLE:
                begin
                    p = (period == 0) ? 1 : longint'(period);
                    span = 4 * p;
                    m = (4 * longint'(t) - p) % span;
                    if (m < 0) m += span;
                    d = m - 2 * p;
                    if (d < 0) d = -d;
                    acc = longint'(freq) * d - (longint'(1) << 32);
                    pending.push_back(round_sat(acc, 19));
                end
                pws_pkg::KIND_SQUARE:
                begin
                    for (int n = 1; n <= h; n++)
                    begin
                        k = 2 * n - 1;
                        coef = (pws_pkg::FOUR_OVER_PI_Q30 + k / 2) / k;
                        acc += table_at(32'(phi * 32'(k))) * coef;
                    end
                    pending.push_back(round_sat(acc, 32));
                end
                default:
                begin
                    for (int n = 1; n <= h; n++)
                    begin
                        coef = (pws_pkg::TWO_OVER_PI_Q30 + n / 2) / n;
                        term = table_at(32'(phi * 32'(n))) * coef;
                        acc += n[0] ? term : -term;
                    end
                    pending.push_back(round_sat(acc, 32));
                end
            endcase
        endfunction

        task check_result(logic [23:0] data);
            sample_t exp_s;
            if (pending.size() == 0)
            begin
                report("result with nothing expected", longint'(data), 0);
                return;
            end
            exp_s = pending.pop_front();
            if (data[15:0] !== exp_s.sample)
                report("sample mismatch", longint'(data[15:0]), longint'(exp_s.sample));
            if (data[16] !== exp_s.clipped)
                report("clipped mismatch", longint'(data[16]), longint'(exp_s.clipped));
        endtask

        task report(string what, longint got, longint want);
            errors++;
            $display("tb_top: %s got %0h want %0h at %0t", what, got, want, $time);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_wr_en;
    logic [7:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    sample_board board;
    bit          calm;
    bit          hold_rx;
    int          idle_cycles;

    periodic_waveform_sample_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver side with random stalls and one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_time(logic [23:0] t);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        do @(posedge clk); while (!s_tready);
        board.note_time(t);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(pws_pkg::cfg_reg_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic set_all(pws_pkg::wave_kind_t k, logic [31:0] f, logic [23:0] p,
                           logic [5:0] h);
        write_reg(pws_pkg::REG_KIND, 32'(k));
        write_reg(pws_pkg::REG_FREQ, f);
        write_reg(pws_pkg::REG_PERIOD, 32'(p));
        write_reg(pws_pkg::REG_HCOUNT, 32'(h));
    endtask

    function automatic logic [23:0] rand_time();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 255));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [31:0]         f;
        logic [23:0]         p;
        logic [5:0]          h;
        pws_pkg::wave_kind_t k;
        board = new();
        calm = 1'b0;
        hold_rx = 1'b0;
        idle_cycles = 0;
        @(posedge rst_n);
        @(posedge clk);

        // reset defaults, then each waveform at its corners
        send_time(24'd0);
        send_time(24'hFFFFFF);
        drain();
        // ignored register index
        cfg_wr_en <= 1'b1;
        cfg_addr <= 8'd7;
        cfg_wr_data <= 32'hFFFFFFFF;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        set_all(pws_pkg::KIND_SINE, 32'h0100_0000, 24'd1, 6'd1);
        send_time(24'd0);
        send_time(24'd64);
        send_time(24'hFFFFFF);
        drain();
        // zero period, treated as one, with a large freq
        set_all(pws_pkg::KIND_TRIANGLE, 32'hFFFFFFFF, 24'd0, 6'd1);
        send_time(24'd0);
        send_time(24'd1);
        send_time(24'hFFFFFF);
        drain();
        write_reg(pws_pkg::REG_PERIOD, 32'h00FF_FFFF);
        write_reg(pws_pkg::REG_FREQ, 32'd256);
        send_time(24'd0);
        send_time(24'h3FFFFF);
        send_time(24'hFFFFFF);
        drain();
        // zero harmonics, then too many
        set_all(pws_pkg::KIND_SQUARE, 32'h0123_4567, 24'd100, 6'd0);
        send_time(24'd5);
        drain();
        write_reg(pws_pkg::REG_HCOUNT, 32'd63);
        send_time(24'd5);
        send_time(24'hFFFFFF);
        drain();
        set_all(pws_pkg::KIND_SAWTOOTH, 32'h0800_0000, 24'd100, 6'd32);
        send_time(24'd1);
        send_time(24'd3);
        drain();
        write_reg(pws_pkg::REG_HCOUNT, 32'd0);
        send_time(24'd3);
        drain();

        // long receiver hold-off with sine so the queue fills
        set_all(pws_pkg::KIND_SINE, 32'h9E37_79B9, 24'd1000, 6'd1);
        hold_rx = 1'b1;
        for (int i = 0; i < 12; i++)
            send_time(rand_time());
        drain();

        for (int phase = 0; phase < 33; phase++)
        begin
            k = pws_pkg::wave_kind_t'(2'(phase % 4));
            case ($urandom_range(0, 3))
                0: f = 32'($urandom_range(0, 3));
                1: f = 32'hFFFFFFFF - 32'($urandom_range(0, 3));
                default: f = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: p = 24'($urandom_range(0, 2));
                1: p = 24'hFFFFFF - 24'($urandom_range(0, 2));
                default: p = 24'($urandom);
            endcase
            h = (phase % 8 == 2) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
            if (phase == 30)
                calm = 1'b1;
            set_all(k, f, p, h);
            for (int i = 0; i < 50; i++)
                send_time(rand_time());
            drain();
        end

        if (board.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pws_pkg.sv
rtl/core/pws_front.sv
rtl/core/pws_queue.sv
rtl/core/pws_sine_rom.sv
rtl/core/pws_back.sv
rtl/core/periodic_waveform_sample_unit.sv
tb/tb_top.sv
